// ===== sv/ttps_pkg.sv =====
// ----------------------------------------------------------------------------
// ttps_pkg
// Shared types and codes for the transposition table probe/store unit.
// ----------------------------------------------------------------------------
package ttps_pkg;

   // Request operation codes
   typedef enum logic {
      OP_PROBE = 1'b0,
      OP_WRITE = 1'b1
   } ttps_op_type;

   // Node kinds kept in a slot
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_EXACT = 2'd1;
   localparam logic [1:0] KIND_LOWER = 2'd2;
   localparam logic [1:0] KIND_UPPER = 2'd3;

   localparam logic [14:0] MATE_THRESHOLD_RESET = 15'd30000;

   // Saturation limits of the stored score
   localparam logic signed [17:0] SCORE_MAX = 18'sd32767;
   localparam logic signed [17:0] SCORE_MIN = -18'sd32768;

   // Control sequencer states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } ttps_state_type;

   typedef struct packed {
      ttps_op_type        opcode;
      logic [63:0]        key;
      logic signed [15:0] alpha;
      logic signed [15:0] beta;
      logic [7:0]         depth;
      logic [7:0]         plies;
      logic [1:0]         node_kind;
      logic [15:0]        move;
      logic signed [15:0] score;
   } ttps_req_type;

   typedef struct packed {
      logic               hit;
      logic               cutoff_valid;
      logic signed [15:0] cutoff_value;
      logic [15:0]        entry_move;
      logic [1:0]         entry_kind;
      logic [7:0]         entry_depth;
   } ttps_rsp_type;

   // One table slot
   typedef struct packed {
      logic [63:0]        key;
      logic [1:0]         kind;
      logic [15:0]        move;
      logic signed [15:0] score;
      logic [7:0]         depth;
   } ttps_entry_type;

   // Write-back request from the evaluator to the table
   typedef struct packed {
      logic           en;
      ttps_entry_type entry;
   } ttps_wb_type;

endpackage

// ===== sv/transposition_table_probe_store_unit.sv =====
// ----------------------------------------------------------------------------
// transposition_table_probe_store_unit
// Direct-mapped, always-replace transposition table with mate score
// ply correction and alpha/beta cutoff reporting.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the whole slot memory to zero, one slot per
// cycle; req_ready stays low for the whole sweep while csr writes are taken
// as usual. Afterwards the slot of each request (probe or write) is read
// from the synchronous memory as it is accepted, then evaluated and written
// back; a new request is taken only once the previous one has left its
// evaluate step. A response waits in an output register, so the next
// request is accepted while it is still pending; that request then holds
// in its evaluate step until the response is taken.
// ----------------------------------------------------------------------------
module transposition_table_probe_store_unit #(
   parameter int INDEX_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ttps_pkg::ttps_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ttps_pkg::ttps_rsp_type rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [14:0]            csr_data
);

   ttps_pkg::ttps_state_type state_ff;
   ttps_pkg::ttps_state_type state_in;
   logic [INDEX_BITS-1:0]    clear_addr_ff;
   logic [INDEX_BITS-1:0]    clear_addr_in;
   ttps_pkg::ttps_req_type   req_ff;
   ttps_pkg::ttps_rsp_type   rsp_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [14:0]              mate_threshold_ff;

   logic                     req_accept;
   logic                     lookup_done;
   logic                     rsp_load;
   logic                     wr_en;
   logic [INDEX_BITS-1:0]    wr_addr;
   ttps_pkg::ttps_entry_type wr_data;
   ttps_pkg::ttps_entry_type rd_data;
   ttps_pkg::ttps_rsp_type   eval_rsp;
   ttps_pkg::ttps_wb_type    eval_wb;

   assign req_accept  = req_valid && req_ready;
   assign lookup_done = !rsp_valid_ff || rsp_ready;

   // Slot memory
   ttps_ram #(
      .ADDR_BITS(INDEX_BITS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (req_accept),
      .rd_addr(req_payload.key[INDEX_BITS-1:0]),
      .rd_data(rd_data)
   );

   // Request evaluation
   ttps_eval u_eval (
      .req           (req_ff),
      .slot          (rd_data),
      .mate_threshold(mate_threshold_ff),
      .rsp           (eval_rsp),
      .wb            (eval_wb)
   );

   // Next state
   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      unique case (state_ff)
         ttps_pkg::ST_CLEAR: begin
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == '1) begin
               state_in = ttps_pkg::ST_IDLE;
            end
         end
         ttps_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = ttps_pkg::ST_LOOKUP;
            end
         end
         ttps_pkg::ST_LOOKUP: begin
            if (lookup_done) begin
               state_in = ttps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ttps_pkg::ST_CLEAR;
         end
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = req_ff.key[INDEX_BITS-1:0];
      wr_data   = eval_wb.entry;
      unique case (state_ff)
         ttps_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clear_addr_ff;
            wr_data = '0;
         end
         ttps_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         ttps_pkg::ST_LOOKUP: begin
            rsp_load = lookup_done;
            wr_en    = lookup_done && eval_wb.en;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Hold or drop the pending response
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ttps_pkg::ST_CLEAR;
         clear_addr_ff     <= '0;
         rsp_valid_ff      <= 1'b0;
         mate_threshold_ff <= ttps_pkg::MATE_THRESHOLD_RESET;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            mate_threshold_ff <= csr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_payload;
      end
      if (rsp_load) begin
         rsp_ff <= eval_rsp;
      end
   end

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== sv/ttps_ram.sv =====
// ----------------------------------------------------------------------------
// ttps_ram
// Simple dual-port slot memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ttps_ram #(
   parameter int ADDR_BITS = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_BITS-1:0]     wr_addr,
   input  ttps_pkg::ttps_entry_type wr_data,
   input  logic                     rd_en,
   input  logic [ADDR_BITS-1:0]     rd_addr,
   output ttps_pkg::ttps_entry_type rd_data
);

   ttps_pkg::ttps_entry_type mem [2**ADDR_BITS];
   ttps_pkg::ttps_entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered, hold data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ttps_eval.sv =====
// ----------------------------------------------------------------------------
// ttps_eval
// Evaluate one request against the slot read from the table: build the
// response and the write-back (store on write, clear on probe miss).
// ----------------------------------------------------------------------------
module ttps_eval (
   input  ttps_pkg::ttps_req_type   req,
   input  ttps_pkg::ttps_entry_type slot,
   input  logic [14:0]              mate_threshold,
   output ttps_pkg::ttps_rsp_type   rsp,
   output ttps_pkg::ttps_wb_type    wb
);

   localparam logic signed [17:0] SCORE_MAX_L = ttps_pkg::SCORE_MAX;
   localparam logic signed [17:0] SCORE_MIN_L = ttps_pkg::SCORE_MIN;

   logic signed [17:0] thr_pos;
   logic signed [17:0] thr_neg;
   logic signed [17:0] plies_ext;
   logic signed [17:0] wr_score;
   logic signed [17:0] wr_adj;
   logic signed [15:0] wr_sat;
   logic signed [17:0] rd_score;
   logic signed [17:0] rd_adj;
   logic signed [17:0] alpha_ext;
   logic signed [17:0] beta_ext;
   logic               tag_hit;
   logic               deep_enough;

   assign thr_pos   = {3'b000, mate_threshold};
   assign thr_neg   = -thr_pos;
   assign plies_ext = {10'b0, req.plies};
   assign wr_score  = {{2{req.score[15]}}, req.score};
   assign rd_score  = {{2{slot.score[15]}}, slot.score};
   assign alpha_ext = {{2{req.alpha[15]}}, req.alpha};
   assign beta_ext  = {{2{req.beta[15]}}, req.beta};

   assign tag_hit     = (slot.key == req.key);
   assign deep_enough = (slot.depth >= req.depth);

   // Make a mate score ply-independent before storing, then saturate
   always_comb begin
      priority if (wr_score > thr_pos) begin
         wr_adj = wr_score + plies_ext;
      end else if (wr_score < thr_neg) begin
         wr_adj = wr_score - plies_ext;
      end else begin
         wr_adj = wr_score;
      end
      priority if (wr_adj > SCORE_MAX_L) begin
         wr_sat = 16'sh7FFF;
      end else if (wr_adj < SCORE_MIN_L) begin
         wr_sat = 16'sh8000;
      end else begin
         wr_sat = wr_adj[15:0];
      end
   end

   // Undo the ply correction on a stored mate score
   always_comb begin
      priority if (rd_score > thr_pos) begin
         rd_adj = rd_score - plies_ext;
      end else if (rd_score < thr_neg) begin
         rd_adj = rd_score + plies_ext;
      end else begin
         rd_adj = rd_score;
      end
   end

   // Response and write-back
   always_comb begin
      rsp = '0;
      wb  = '0;
      if (req.opcode == ttps_pkg::OP_WRITE) begin
         wb.en          = 1'b1;
         wb.entry.key   = req.key;
         wb.entry.kind  = req.node_kind;
         wb.entry.move  = req.move;
         wb.entry.score = wr_sat;
         wb.entry.depth = req.depth;
      end else if (!tag_hit) begin
         // Miss: clear the slot
         wb.en = 1'b1;
      end else begin
         rsp.hit         = 1'b1;
         rsp.entry_move  = slot.move;
         rsp.entry_kind  = slot.kind;
         rsp.entry_depth = slot.depth;
         if (deep_enough) begin
            priority if (slot.kind == ttps_pkg::KIND_UPPER && rd_adj <= alpha_ext) begin
               rsp.cutoff_valid = 1'b1;
               rsp.cutoff_value = req.alpha;
            end else if (slot.kind == ttps_pkg::KIND_LOWER && rd_adj >= beta_ext) begin
               rsp.cutoff_valid = 1'b1;
               rsp.cutoff_value = req.beta;
            end else if (slot.kind == ttps_pkg::KIND_EXACT) begin
               rsp.cutoff_valid = 1'b1;
               rsp.cutoff_value = rd_adj[15:0];
            end else begin
               rsp.cutoff_valid = 1'b0;
            end
         end
      end
   end

endmodule

// ===== sv/ttps_checker.sv =====
// ----------------------------------------------------------------------------
// ttps_checker
// Port-level checks for the transposition table probe/store unit.
// ----------------------------------------------------------------------------
module ttps_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input ttps_pkg::ttps_req_type req_payload,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input ttps_pkg::ttps_rsp_type rsp_payload,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic [14:0]            csr_data
);

   // Pending response holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("pending response changed before it was taken");

   // One request in flight: no back-to-back accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one still in lookup");

   // A miss or a write reports nothing from the slot
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.hit |->
         !rsp_payload.cutoff_valid && rsp_payload.entry_move == 16'd0 &&
         rsp_payload.entry_kind == 2'd0 && rsp_payload.entry_depth == 8'd0)
      else $error("response without hit carries slot data");

   // No cutoff means a zero cutoff value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.cutoff_valid |-> rsp_payload.cutoff_value == 16'sd0)
      else $error("cutoff value set without cutoff");

endmodule

bind transposition_table_probe_store_unit ttps_checker u_ttps_checker (.*);

// ===== bench/transposition_table_probe_store_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// transposition_table_probe_store_unit_test
// Self-checking bench for the transposition table probe/store unit: a typed
// table of directed requests, then random probe/write traffic over a small
// pool of colliding keys, checked against a behavioral table image while both
// handshakes idle at random and the mate threshold is swept.
// ----------------------------------------------------------------------------
module transposition_table_probe_store_unit_test;

   localparam int INDEX_BITS = 16;
   // The clearing sweep after reset keeps req_ready low for a full table pass
   localparam int STALL_LIMIT = 4 * (1 << INDEX_BITS) + 1000;
   localparam int POOL_SIZE = 16;
   localparam int BLOCK_ITEMS = 50;

   typedef struct {
      ttps_pkg::ttps_req_type req;
      bit                     typed;
      ttps_pkg::ttps_rsp_type rsp;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   ttps_pkg::ttps_req_type req_payload;
   logic                   rsp_valid;
   logic                   rsp_ready;
   ttps_pkg::ttps_rsp_type rsp_payload;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [14:0]            csr_data;

   // Expectation source travelling alongside each request
   logic                   row_typed;
   ttps_pkg::ttps_rsp_type row_rsp;

   // Behavioral image of the table and its threshold register
   ttps_pkg::ttps_entry_type slot_img [int unsigned];
   logic [14:0]              thr_model;
   ttps_pkg::ttps_rsp_type   expected_rsp [$];

   stim_row_type directed_rows [$];
   logic [63:0]  key_pool [POOL_SIZE];
   int           cur_thr;
   int           send_idle_pct;
   int           rcv_idle_pct;
   int           errors;
   int           rsp_count;
   int           stall_cycles;
   int           write_count;
   int           probe_count;
   int           hit_count;
   int           cutoff_count;
   int           thr_settings;

   always #5 clock = ~clock;

   transposition_table_probe_store_unit #(
      .INDEX_BITS(INDEX_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Compute the response of one request and update the table image
   function automatic ttps_pkg::ttps_rsp_type predict_table_access(
      input ttps_pkg::ttps_req_type r);
      ttps_pkg::ttps_rsp_type   res;
      ttps_pkg::ttps_entry_type ent;
      int unsigned              idx;
      int                       s;
      int                       t;
      int                       p;
      res = '0;
      idx = r.key[INDEX_BITS-1:0];
      t = int'(thr_model);
      p = int'(r.plies);
      ent = slot_img.exists(idx) ? slot_img[idx] : '0;
      if (r.opcode == ttps_pkg::OP_WRITE) begin
         // Make mate scores ply-independent, then saturate
         s = $signed(r.score);
         if (s > t) s = s + p;
         else if (s < -t) s = s - p;
         if (s > ttps_pkg::SCORE_MAX) s = ttps_pkg::SCORE_MAX;
         if (s < ttps_pkg::SCORE_MIN) s = ttps_pkg::SCORE_MIN;
         ent.key = r.key;
         ent.kind = r.node_kind;
         ent.move = r.move;
         ent.score = 16'(s);
         ent.depth = r.depth;
         slot_img[idx] = ent;
         return res;
      end
      // Drop the slot on a tag miss
      if (ent.key != r.key) begin
         if (slot_img.exists(idx)) slot_img.delete(idx);
         return res;
      end
      res.hit = 1'b1;
      res.entry_move = ent.move;
      res.entry_kind = ent.kind;
      res.entry_depth = ent.depth;
      if (ent.depth >= r.depth) begin
         // Undo the ply correction before the bound tests
         s = $signed(ent.score);
         if (s > t) s = s - p;
         else if (s < -t) s = s + p;
         if (ent.kind == ttps_pkg::KIND_UPPER && s <= $signed(r.alpha)) begin
            res.cutoff_valid = 1'b1;
            res.cutoff_value = r.alpha;
         end else if (ent.kind == ttps_pkg::KIND_LOWER && s >= $signed(r.beta)) begin
            res.cutoff_valid = 1'b1;
            res.cutoff_value = r.beta;
         end else if (ent.kind == ttps_pkg::KIND_EXACT) begin
            res.cutoff_valid = 1'b1;
            res.cutoff_value = 16'(s);
         end
      end
      return res;
   endfunction

   function automatic ttps_pkg::ttps_req_type mk_req(input ttps_pkg::ttps_op_type op,
                                                     input logic [63:0] k,
                                                     input int a, input int b, input int d,
                                                     input int p, input logic [1:0] kd,
                                                     input int mv, input int sc);
      ttps_pkg::ttps_req_type r;
      r.opcode = op;
      r.key = k;
      r.alpha = 16'(a);
      r.beta = 16'(b);
      r.depth = 8'(d);
      r.plies = 8'(p);
      r.node_kind = kd;
      r.move = 16'(mv);
      r.score = 16'(sc);
      return r;
   endfunction

   task automatic add_row(input ttps_pkg::ttps_req_type r, input bit typed,
                          input ttps_pkg::ttps_rsp_type rsp);
      stim_row_type row;
      row.req = r;
      row.typed = typed;
      row.rsp = rsp;
      directed_rows.push_back(row);
   endtask

   function automatic logic [63:0] fresh_key();
      logic [63:0] k;
      k = {$urandom, $urandom};
      // Keep most keys on a few slots so tags collide
      if ($urandom_range(9) != 0) k[15:0] = 16'($urandom_range(7));
      return k;
   endfunction

   // Scores and bounds cluster around the mate threshold and the extremes
   function automatic logic signed [15:0] pick_score();
      int v;
      case ($urandom_range(7))
         0: v = $urandom;
         1: v = cur_thr + $urandom_range(300);
         2: v = -cur_thr - $urandom_range(300);
         3: v = cur_thr;
         4: v = -cur_thr;
         5: v = 32767;
         6: v = -32768;
         default: v = $urandom_range(400) - 200;
      endcase
      return 16'(v);
   endfunction

   function automatic ttps_pkg::ttps_req_type random_request();
      ttps_pkg::ttps_req_type r;
      logic [159:0]           raw;
      int                     sel;
      int                     pick;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      r = raw[$bits(ttps_pkg::ttps_req_type)-1:0];
      sel = $urandom_range(POOL_SIZE - 1);
      pick = $urandom_range(99);
      if (pick < 40) begin
         r.opcode = ttps_pkg::OP_WRITE;
         r.key = key_pool[sel];
      end else if (pick < 85) begin
         r.opcode = ttps_pkg::OP_PROBE;
         r.key = key_pool[sel];
      end else if (pick < 95) begin
         // Same slot, different tag
         r.opcode = ttps_pkg::OP_PROBE;
         r.key = key_pool[sel] ^ (64'($urandom_range(1, 65535)) << 16);
      end
      r.score = pick_score();
      r.alpha = pick_score();
      r.beta = pick_score();
      if (r.opcode == ttps_pkg::OP_WRITE) r.depth = 8'($urandom_range(255));
      else if ($urandom_range(3) != 0) r.depth = 8'($urandom_range(12));
      if ($urandom_range(19) == 0) key_pool[sel] = fresh_key();
      return r;
   endfunction

   function automatic int threshold_for_block(input int n);
      case (n % 6)
         0: return 0;
         1: return 32767;
         2: return 30000;
         3: return $urandom_range(1, 32766);
         4: return 100;
         default: return 32766;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int got_v, input int want_v);
      errors++;
      // Print the first hundred, count the rest
      if (errors <= 100)
         $display("%0t: response %0d %s: got %0d, expected %0d",
                  $time, rsp_count, what, got_v, want_v);
   endtask

   task automatic check_response(input ttps_pkg::ttps_rsp_type got);
      ttps_pkg::ttps_rsp_type want;
      if (expected_rsp.size() == 0) begin
         report_mismatch("arrived with nothing outstanding", 1, 0);
         return;
      end
      want = expected_rsp.pop_front();
      if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
      if (got.cutoff_valid !== want.cutoff_valid)
         report_mismatch("cutoff_valid", got.cutoff_valid, want.cutoff_valid);
      if (got.cutoff_value !== want.cutoff_value)
         report_mismatch("cutoff_value", $signed(got.cutoff_value),
                         $signed(want.cutoff_value));
      if (got.entry_move !== want.entry_move)
         report_mismatch("entry_move", got.entry_move, want.entry_move);
      if (got.entry_kind !== want.entry_kind)
         report_mismatch("entry_kind", got.entry_kind, want.entry_kind);
      if (got.entry_depth !== want.entry_depth)
         report_mismatch("entry_depth", got.entry_depth, want.entry_depth);
      if (got.hit === 1'b1) hit_count++;
      if (got.cutoff_valid === 1'b1) cutoff_count++;
   endtask

   // Monitor all three channels, predict, check and watch for a hang
   always @(posedge clock) begin : monitor_blk
      ttps_pkg::ttps_rsp_type predicted;
      if (reset) begin
         thr_model = ttps_pkg::MATE_THRESHOLD_RESET;
         slot_img.delete();
         expected_rsp.delete();
         stall_cycles = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            check_response(rsp_payload);
         end
         if (req_valid && req_ready) begin
            predicted = predict_table_access(req_payload);
            expected_rsp.push_back(row_typed ? row_rsp : predicted);
            if (req_payload.opcode == ttps_pkg::OP_WRITE) write_count++;
            else probe_count++;
         end
         if (csr_valid && csr_ready) thr_model = csr_data;
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
               $display("timeout: no handshake for %0d cycles", stall_cycles);
               $display("transposition_table_probe_store_unit: mismatch");
               $finish;
            end
         end
      end
   end

   // Stall the response side at random
   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= rcv_idle_pct);
   end

   task automatic send_request(input ttps_pkg::ttps_req_type r, input bit typed,
                               input ttps_pkg::ttps_rsp_type rsp);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      row_typed <= typed;
      row_rsp <= rsp;
      do @(posedge clock); while (!req_ready);
   endtask

   // Hold off new requests until every response is back
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_threshold(input int value);
      csr_valid <= 1'b1;
      csr_data <= 15'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_thr = value;
      thr_settings++;
   endtask

   initial begin : stimulus_blk
      ttps_pkg::ttps_rsp_type zero_rsp;
      ttps_pkg::ttps_rsp_type hit_only;
      ttps_pkg::ttps_rsp_type top_exact;
      logic [63:0]            k1;
      logic [63:0]            k2;
      logic [63:0]            k3;
      logic [63:0]            k4;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      row_typed <= 1'b0;
      row_rsp <= '0;
      errors = 0;
      rsp_count = 0;
      write_count = 0;
      probe_count = 0;
      hit_count = 0;
      cutoff_count = 0;
      thr_settings = 1;
      cur_thr = ttps_pkg::MATE_THRESHOLD_RESET;
      send_idle_pct = 21;
      rcv_idle_pct = 76;
      foreach (key_pool[i]) key_pool[i] = fresh_key();

      zero_rsp = '0;
      hit_only = '{1'b1, 1'b0, 16'sd0, 16'h0, ttps_pkg::KIND_NONE, 8'd0};
      top_exact = '{1'b1, 1'b1, 16'sd32767, 16'hFFFF, ttps_pkg::KIND_EXACT, 8'd255};
      k1 = 64'hFFFF_FFFF_FFFF_FFFF;
      k2 = 64'h8000_0000_0000_1234;
      k3 = 64'h0123_4567_89AB_0040;
      k4 = 64'h7654_3210_FEDC_0040;

      // Cleared slot holds tag zero: key zero hits it, only depth zero passes
      add_row(mk_req(ttps_pkg::OP_PROBE, 64'h0, 0, 0, 0, 0, ttps_pkg::KIND_NONE, 0, 0),
              1, hit_only);
      add_row(mk_req(ttps_pkg::OP_PROBE, 64'h0, 0, 0, 1, 0, ttps_pkg::KIND_NONE, 0, 0),
              1, hit_only);
      add_row(mk_req(ttps_pkg::OP_PROBE, 64'h1_0000, 0, 0, 1, 0, ttps_pkg::KIND_NONE, 0, 0),
              1, zero_rsp);
      // Top score saturates after the ply correction
      add_row(mk_req(ttps_pkg::OP_WRITE, k1, 0, 0, 255, 255, ttps_pkg::KIND_EXACT,
                     16'hFFFF, 32767), 1, zero_rsp);
      add_row(mk_req(ttps_pkg::OP_PROBE, k1, 0, 0, 255, 0, ttps_pkg::KIND_NONE, 0, 0),
              1, top_exact);
      add_row(mk_req(ttps_pkg::OP_PROBE, k1, 0, 0, 255, 255, ttps_pkg::KIND_NONE, 0, 0),
              0, zero_rsp);
      add_row(mk_req(ttps_pkg::OP_PROBE, k1, -32768, 32767, 0, 200, ttps_pkg::KIND_NONE,
                     0, 0), 0, zero_rsp);
      // Bottom score saturates, then lower-bound cutoffs
      add_row(mk_req(ttps_pkg::OP_WRITE, k2, 0, 0, 1, 255, ttps_pkg::KIND_LOWER, 0, -32768),
              1, zero_rsp);
      add_row(mk_req(ttps_pkg::OP_PROBE, k2, 0, -32767, 1, 10, ttps_pkg::KIND_NONE, 0, 0),
              0, zero_rsp);
      add_row(mk_req(ttps_pkg::OP_PROBE, k2, 0, -32768, 1, 0, ttps_pkg::KIND_NONE, 0, 0),
              0, zero_rsp);
      add_row(mk_req(ttps_pkg::OP_PROBE, k2, 0, -32768, 2, 0, ttps_pkg::KIND_NONE, 0, 0),
              0, zero_rsp);
      // Upper bound against alpha, then a kind with no cutoff
      add_row(mk_req(ttps_pkg::OP_WRITE, k3, 0, 0, 8, 0, ttps_pkg::KIND_UPPER, 16'h1234, -5),
              1, zero_rsp);
      add_row(mk_req(ttps_pkg::OP_PROBE, k3, 0, 0, 8, 0, ttps_pkg::KIND_NONE, 0, 0),
              0, zero_rsp);
      add_row(mk_req(ttps_pkg::OP_PROBE, k3, -10, 0, 8, 0, ttps_pkg::KIND_NONE, 0, 0),
              0, zero_rsp);
      add_row(mk_req(ttps_pkg::OP_WRITE, k3, 0, 0, 8, 0, ttps_pkg::KIND_NONE, 16'h4321, 100),
              1, zero_rsp);
      add_row(mk_req(ttps_pkg::OP_PROBE, k3, -32768, -32768, 3, 0, ttps_pkg::KIND_NONE,
                     0, 0), 0, zero_rsp);
      // Tag miss on the same slot clears it
      add_row(mk_req(ttps_pkg::OP_PROBE, k4, 0, 0, 0, 0, ttps_pkg::KIND_NONE, 0, 0),
              1, zero_rsp);
      add_row(mk_req(ttps_pkg::OP_PROBE, k3, 0, 0, 0, 0, ttps_pkg::KIND_NONE, 0, 0),
              1, zero_rsp);
      // Just past the threshold on both sides
      add_row(mk_req(ttps_pkg::OP_WRITE, k4, 0, 0, 20, 7, ttps_pkg::KIND_EXACT,
                     16'h8001, 30001), 1, zero_rsp);
      add_row(mk_req(ttps_pkg::OP_PROBE, k4, 0, 0, 20, 3, ttps_pkg::KIND_NONE, 0, 0),
              0, zero_rsp);
      add_row(mk_req(ttps_pkg::OP_WRITE, 64'h0, 0, 0, 0, 9, ttps_pkg::KIND_LOWER,
                     16'h00FF, 32767), 1, zero_rsp);
      add_row(mk_req(ttps_pkg::OP_PROBE, 64'h0, 0, 32767, 0, 0, ttps_pkg::KIND_NONE, 0, 0),
              0, zero_rsp);
      add_row(mk_req(ttps_pkg::OP_WRITE, k2, 0, 0, 40, 255, ttps_pkg::KIND_EXACT,
                     16'h7777, -30001), 1, zero_rsp);
      add_row(mk_req(ttps_pkg::OP_PROBE, k2, 0, 0, 0, 255, ttps_pkg::KIND_NONE, 0, 0),
              0, zero_rsp);
      add_row(mk_req(ttps_pkg::OP_PROBE, k1, 32767, -32768, 1, 1, ttps_pkg::KIND_LOWER,
                     16'hAAAA, 0), 0, zero_rsp);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table at the reset threshold
      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
      drain_responses();

      // Random traffic: three idling modes, threshold changed per block
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 21;
               rcv_idle_pct = 76;
            end
            1: begin
               send_idle_pct = 76;
               rcv_idle_pct = 21;
            end
            default: begin
               send_idle_pct = 0;
               rcv_idle_pct = 0;
            end
         endcase
         for (int blk = 0; blk < 4; blk++) begin
            write_threshold(threshold_for_block(phase * 4 + blk));
            repeat (BLOCK_ITEMS) send_request(random_request(), 1'b0, '0);
            drain_responses();
         end
      end

      repeat (20) @(posedge clock);
      $display("Ran %0d writes and %0d probes (%0d hits, %0d cutoffs)",
               write_count, probe_count, hit_count, cutoff_count);
      $display("over %0d mate threshold settings with both sides stalling",
               thr_settings);
      if (errors == 0) begin
         $display("transposition_table_probe_store_unit: match");
      end else begin
         $display("transposition_table_probe_store_unit: mismatch");
      end
      $finish;
   end

endmodule
